// ===== rtl/core/wcnf_stream_parser_unit_assert.svh =====
// assertion macros used by the wcnf stream parser port checker
`ifndef WCNF_STREAM_PARSER_UNIT_ASSERT_SVH
`define WCNF_STREAM_PARSER_UNIT_ASSERT_SVH

// same-cycle implication on clk, disabled while rst_n is low
`define WSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, disabled while rst_n is low
`define WSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wsp_pkg.sv =====
// types, codes and character helpers for the wcnf stream parser
package wsp_pkg;

    localparam int FIELD_W  = 24;
    localparam int HW_W     = 31;
    localparam int HEAD_LEN = 6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic [2:0]         event_res;
        logic [FIELD_W-1:0] var_index;
        logic               negated;
        logic               soft_clause;
        logic [FIELD_W-1:0] count_value;
        logic [HW_W-1:0]    hard_weight;
        logic [2:0]         error_code;
        logic               last_of_run;
    } result_t;

    // results produced by one item, handed to the output queue
    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

    localparam logic [2:0] EV_HEADER = 3'd0;
    localparam logic [2:0] EV_START  = 3'd1;
    localparam logic [2:0] EV_LIT    = 3'd2;
    localparam logic [2:0] EV_END    = 3'd3;
    localparam logic [2:0] EV_DONE   = 3'd4;
    localparam logic [2:0] EV_ERROR  = 3'd5;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_CHAR      = 3'd1;
    localparam logic [2:0] ERR_NO_HEADER = 3'd2;
    localparam logic [2:0] ERR_WEIGHT    = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_C     = "c";
    localparam logic [7:0] CH_P     = "p";

    function automatic logic is_space(input logic [7:0] ch);
        return ch inside {[CH_TAB:CH_CR], CH_SPACE};
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch inside {[CH_ZERO:CH_NINE]};
    endfunction

    // characters of the "p wcnf" header line
    function automatic logic [7:0] head_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = "p";
            3'd1:    ch = " ";
            3'd2:    ch = "w";
            3'd3:    ch = "c";
            3'd4:    ch = "n";
            3'd5:    ch = "f";
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic result_t make_result(
        input logic [2:0]         ev,
        input logic [FIELD_W-1:0] var_idx,
        input logic               neg,
        input logic               soft_flag,
        input logic [FIELD_W-1:0] cnt,
        input logic [HW_W-1:0]    hw,
        input logic [2:0]         err
    );
        result_t r;
        r.event_res   = ev;
        r.var_index   = var_idx;
        r.negated     = neg;
        r.soft_clause = soft_flag;
        r.count_value = cnt;
        r.hard_weight = hw;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/core/wsp_core.sv =====
// input register and parser state with the per-byte decode logic
module wsp_core #(
    parameter int VAR_BITS = 24,
    parameter int NUM_BITS = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  wsp_pkg::item_t   item,
    input  logic             room,
    output wsp_pkg::push_t   push
);
    import wsp_pkg::*;

    localparam int ACC_W  = (NUM_BITS < 31) ? NUM_BITS : 31;
    localparam int PROD_W = ACC_W + 4;
    localparam int CMP_W  = ((ACC_W > VAR_BITS) ? ACC_W : VAR_BITS) + 1;

    localparam logic [ACC_W-1:0]    ACC_MAX = '1;
    localparam logic [VAR_BITS-1:0] VAR_MAX = '1;
    localparam logic [CMP_W-1:0]    VMAX_C  = CMP_W'(VAR_MAX);
    localparam logic [CMP_W-1:0]    VMAX_P1 = VMAX_C + CMP_W'(1);

    localparam logic [1:0] HF_VARS    = 2'd0;
    localparam logic [1:0] HF_CLAUSES = 2'd1;
    localparam logic [1:0] HF_TOP     = 2'd2;

    typedef enum logic [6:0] {
        PH_SEARCH  = 7'b0000001,
        PH_MATCH   = 7'b0000010,
        PH_HEAD    = 7'b0000100,
        PH_IDLE    = 7'b0001000,
        PH_WEIGHT  = 7'b0010000,
        PH_LITS    = 7'b0100000,
        PH_DISCARD = 7'b1000000
    } phase_t;

    logic                item_valid_reg, item_valid_next;
    item_t               item_reg;
    logic                process;

    phase_t              phase_reg, phase_next;
    logic [2:0]          match_pos_reg, match_pos_next;
    logic [ACC_W-1:0]    accum_reg, accum_next;
    logic                minus_seen_reg, minus_seen_next;
    logic                plus_seen_reg, plus_seen_next;
    logic                digits_seen_reg, digits_seen_next;
    logic [1:0]          header_field_reg, header_field_next;
    logic [VAR_BITS-1:0] var_count_reg, var_count_next;
    logic [VAR_BITS-1:0] clause_count_reg, clause_count_next;
    logic [ACC_W-1:0]    header_top_reg, header_top_next;
    logic [VAR_BITS-1:0] soft_count_reg, soft_count_next;
    logic [VAR_BITS-1:0] next_free_var_reg, next_free_var_next;
    logic                skipping_line_reg, skipping_line_next;

    logic [7:0]          c;
    logic                eoi;
    logic                go;
    logic                num_ph;
    logic                do_fin;
    logic                idle_tok;
    logic                num_tok;
    logic                do_add;
    logic                neg;
    logic [CMP_W-1:0]    mag_c;
    logic [ACC_W-1:0]    lit;
    logic [PROD_W-1:0]   sum;
    logic [2:0]          err;
    logic [1:0]          n_ev;
    result_t             res [2];

    assign process         = item_valid_reg & room;
    assign item_ready      = ~item_valid_reg | room;
    assign item_valid_next = (item_valid & item_ready) | (item_valid_reg & ~process);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    always_comb
    begin
        c    = item_reg.data_byte;
        eoi  = item_reg.end_of_input;

        phase_next         = phase_reg;
        match_pos_next     = match_pos_reg;
        accum_next         = accum_reg;
        minus_seen_next    = minus_seen_reg;
        plus_seen_next     = plus_seen_reg;
        digits_seen_next   = digits_seen_reg;
        header_field_next  = header_field_reg;
        var_count_next     = var_count_reg;
        clause_count_next  = clause_count_reg;
        header_top_next    = header_top_reg;
        soft_count_next    = soft_count_reg;
        next_free_var_next = next_free_var_reg;
        skipping_line_next = skipping_line_reg;

        n_ev     = 2'd0;
        res[0]   = '0;
        res[1]   = '0;
        go       = 1'b1;
        idle_tok = 1'b0;
        num_tok  = 1'b0;
        do_add   = 1'b0;
        err      = ERR_NONE;
        sum      = '0;
        neg      = minus_seen_reg && (accum_reg != '0);
        mag_c    = CMP_W'(accum_reg);
        lit      = accum_reg - ACC_W'(1);

        // comment line: newline ends it quietly, nul ends it and is decoded
        if (!eoi && skipping_line_reg)
        begin
            if (c == CH_LF)
            begin
                skipping_line_next = 1'b0;
                go = 1'b0;
            end
            else if (c != CH_NUL)
            begin
                go = 1'b0;
            end
            else
            begin
                skipping_line_next = 1'b0;
            end
        end

        num_ph = phase_reg inside {PH_HEAD, PH_WEIGHT, PH_LITS, PH_DISCARD};
        do_fin = eoi ? digits_seen_reg
                     : (go && num_ph && digits_seen_reg && !is_digit(c));

        // close the pending number
        if (do_fin)
        begin
            accum_next       = '0;
            minus_seen_next  = 1'b0;
            plus_seen_next   = 1'b0;
            digits_seen_next = 1'b0;
            case (phase_reg)
                PH_HEAD:
                begin
                    case (header_field_reg)
                        HF_VARS:
                        begin
                            if (mag_c > VMAX_C)
                            begin
                                res[n_ev[0]] = make_result(EV_ERROR, '0, 1'b0, 1'b0, '0, '0,
                                                           ERR_OVERFLOW);
                                n_ev = n_ev + 2'd1;
                                var_count_next = VAR_MAX;
                            end
                            else
                            begin
                                var_count_next = mag_c[VAR_BITS-1:0];
                            end
                            header_field_next = HF_CLAUSES;
                        end
                        HF_CLAUSES:
                        begin
                            if (mag_c > VMAX_C)
                            begin
                                res[n_ev[0]] = make_result(EV_ERROR, '0, 1'b0, 1'b0, '0, '0,
                                                           ERR_OVERFLOW);
                                n_ev = n_ev + 2'd1;
                                clause_count_next = VAR_MAX;
                            end
                            else
                            begin
                                clause_count_next = mag_c[VAR_BITS-1:0];
                            end
                            header_field_next = HF_TOP;
                        end
                        default:
                        begin
                            header_top_next    = accum_reg;
                            next_free_var_next = var_count_reg;
                            res[n_ev[0]] = make_result(EV_HEADER, FIELD_W'(var_count_reg),
                                                       1'b0, 1'b0,
                                                       FIELD_W'(clause_count_reg),
                                                       HW_W'(accum_reg), ERR_NONE);
                            n_ev = n_ev + 2'd1;
                            header_field_next = HF_VARS;
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                PH_WEIGHT:
                begin
                    if (!neg && accum_reg == ACC_W'(1))
                    begin
                        res[n_ev[0]] = make_result(EV_START, FIELD_W'(next_free_var_reg),
                                                   1'b0, 1'b1, '0, '0, ERR_NONE);
                        n_ev = n_ev + 2'd1;
                        if (next_free_var_reg != VAR_MAX)
                        begin
                            next_free_var_next = next_free_var_reg + VAR_BITS'(1);
                        end
                        if (soft_count_reg != VAR_MAX)
                        begin
                            soft_count_next = soft_count_reg + VAR_BITS'(1);
                        end
                        phase_next = PH_LITS;
                    end
                    else if (!neg && accum_reg == header_top_reg)
                    begin
                        res[n_ev[0]] = make_result(EV_START, '0, 1'b0, 1'b0, '0, '0,
                                                   ERR_NONE);
                        n_ev = n_ev + 2'd1;
                        phase_next = PH_LITS;
                    end
                    else
                    begin
                        res[n_ev[0]] = make_result(EV_ERROR, '0, 1'b0, 1'b0, '0, '0,
                                                   ERR_WEIGHT);
                        n_ev = n_ev + 2'd1;
                        phase_next = PH_DISCARD;
                    end
                end
                PH_LITS:
                begin
                    if (accum_reg == '0)
                    begin
                        res[n_ev[0]] = make_result(EV_END, '0, 1'b0, 1'b0, '0, '0,
                                                   ERR_NONE);
                        n_ev = n_ev + 2'd1;
                        phase_next = PH_IDLE;
                    end
                    else if (mag_c > VMAX_P1)
                    begin
                        res[n_ev[0]] = make_result(EV_ERROR, '0, 1'b0, 1'b0, '0, '0,
                                                   ERR_OVERFLOW);
                        n_ev = n_ev + 2'd1;
                    end
                    else
                    begin
                        res[n_ev[0]] = make_result(EV_LIT, FIELD_W'(lit), neg, 1'b0,
                                                   '0, '0, ERR_NONE);
                        n_ev = n_ev + 2'd1;
                    end
                end
                PH_DISCARD:
                begin
                    if (accum_reg == '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (eoi)
        begin
            if (phase_next == PH_SEARCH)
            begin
                err = ERR_NO_HEADER;
            end
            else if (phase_next == PH_IDLE)
            begin
                err = ERR_NONE;
            end
            else
            begin
                err = ERR_CHAR;
            end
            res[n_ev[0]] = make_result(EV_DONE, '0, 1'b0, 1'b0, FIELD_W'(soft_count_next),
                                       '0, err);
            n_ev = n_ev + 2'd1;

            phase_next         = PH_SEARCH;
            match_pos_next     = '0;
            accum_next         = '0;
            minus_seen_next    = 1'b0;
            plus_seen_next     = 1'b0;
            digits_seen_next   = 1'b0;
            header_field_next  = HF_VARS;
            var_count_next     = '0;
            clause_count_next  = '0;
            header_top_next    = '0;
            soft_count_next    = '0;
            next_free_var_next = '0;
            skipping_line_next = 1'b0;
        end
        else if (go)
        begin
            if (do_fin)
            begin
                // the byte that closed the number starts the next token
                if (phase_next == PH_IDLE)
                begin
                    idle_tok = 1'b1;
                end
                else
                begin
                    num_tok = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_SEARCH:
                    begin
                        if (is_space(c))
                        begin
                        end
                        else if (c == CH_C)
                        begin
                            skipping_line_next = 1'b1;
                        end
                        else if (c == CH_P)
                        begin
                            phase_next     = PH_MATCH;
                            match_pos_next = 3'd1;
                        end
                        else
                        begin
                            res[n_ev[0]] = make_result(EV_ERROR, '0, 1'b0, 1'b0, '0, '0,
                                                       ERR_NO_HEADER);
                            n_ev = n_ev + 2'd1;
                            phase_next = PH_IDLE;
                            idle_tok   = 1'b1;
                        end
                    end
                    PH_MATCH:
                    begin
                        if (match_pos_reg < 3'(HEAD_LEN) && c == head_char(match_pos_reg))
                        begin
                            if (match_pos_reg == 3'(HEAD_LEN - 1))
                            begin
                                match_pos_next    = '0;
                                header_field_next = HF_VARS;
                                phase_next        = PH_HEAD;
                            end
                            else
                            begin
                                match_pos_next = match_pos_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            res[n_ev[0]] = make_result(EV_ERROR, '0, 1'b0, 1'b0, '0, '0,
                                                       ERR_CHAR);
                            n_ev = n_ev + 2'd1;
                            match_pos_next     = '0;
                            phase_next         = PH_IDLE;
                            skipping_line_next = (c != CH_LF);
                        end
                    end
                    PH_IDLE:
                    begin
                        idle_tok = 1'b1;
                    end
                    default:
                    begin
                        if (digits_seen_reg)
                        begin
                            do_add = 1'b1;
                        end
                        else
                        begin
                            num_tok = 1'b1;
                        end
                    end
                endcase
            end

            if (idle_tok)
            begin
                if (is_space(c))
                begin
                end
                else if (c == CH_C || c == CH_P)
                begin
                    skipping_line_next = 1'b1;
                end
                else if (is_digit(c) || c == CH_PLUS || c == CH_MINUS)
                begin
                    phase_next = PH_WEIGHT;
                    num_tok    = 1'b1;
                end
                else
                begin
                    res[n_ev[0]] = make_result(EV_ERROR, '0, 1'b0, 1'b0, '0, '0, ERR_CHAR);
                    n_ev = n_ev + 2'd1;
                end
            end

            // first byte of a number, no digit seen yet
            if (num_tok)
            begin
                if (minus_seen_next || plus_seen_next)
                begin
                    if (is_digit(c))
                    begin
                        do_add = 1'b1;
                    end
                    else
                    begin
                        res[n_ev[0]] = make_result(EV_ERROR, '0, 1'b0, 1'b0, '0, '0,
                                                   ERR_CHAR);
                        n_ev = n_ev + 2'd1;
                    end
                end
                else if (is_space(c))
                begin
                end
                else if (is_digit(c))
                begin
                    do_add = 1'b1;
                end
                else if (c == CH_PLUS)
                begin
                    plus_seen_next = 1'b1;
                end
                else if (c == CH_MINUS && phase_next != PH_HEAD)
                begin
                    minus_seen_next = 1'b1;
                end
                else
                begin
                    res[n_ev[0]] = make_result(EV_ERROR, '0, 1'b0, 1'b0, '0, '0, ERR_CHAR);
                    n_ev = n_ev + 2'd1;
                end
            end

            // accum * 10 + digit, saturating at the number limit
            if (do_add)
            begin
                sum = PROD_W'(accum_next) * PROD_W'(10) + PROD_W'(c[3:0]);
                if (sum > PROD_W'(ACC_MAX))
                begin
                    accum_next = ACC_MAX;
                    res[n_ev[0]] = make_result(EV_ERROR, '0, 1'b0, 1'b0, '0, '0,
                                               ERR_OVERFLOW);
                    n_ev = n_ev + 2'd1;
                end
                else
                begin
                    accum_next = sum[ACC_W-1:0];
                end
                digits_seen_next = 1'b1;
            end
        end

        if (n_ev != 2'd0)
        begin
            res[1'(n_ev - 2'd1)].last_of_run = 1'b1;
        end
    end

    assign push.num    = process ? n_ev : 2'd0;
    assign push.first  = res[0];
    assign push.second = res[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SEARCH;
            match_pos_reg     <= '0;
            accum_reg         <= '0;
            minus_seen_reg    <= 1'b0;
            plus_seen_reg     <= 1'b0;
            digits_seen_reg   <= 1'b0;
            header_field_reg  <= HF_VARS;
            var_count_reg     <= '0;
            clause_count_reg  <= '0;
            header_top_reg    <= '0;
            soft_count_reg    <= '0;
            next_free_var_reg <= '0;
            skipping_line_reg <= 1'b0;
        end
        else if (process)
        begin
            phase_reg         <= phase_next;
            match_pos_reg     <= match_pos_next;
            accum_reg         <= accum_next;
            minus_seen_reg    <= minus_seen_next;
            plus_seen_reg     <= plus_seen_next;
            digits_seen_reg   <= digits_seen_next;
            header_field_reg  <= header_field_next;
            var_count_reg     <= var_count_next;
            clause_count_reg  <= clause_count_next;
            header_top_reg    <= header_top_next;
            soft_count_reg    <= soft_count_next;
            next_free_var_reg <= next_free_var_next;
            skipping_line_reg <= skipping_line_next;
        end
    end

endmodule

// ===== rtl/core/wsp_out_queue.sv =====
// three-entry result queue, takes up to two results per cycle while room is high
module wsp_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  wsp_pkg::push_t   push,
    output logic             room,
    output logic             result_valid,
    input  logic             result_ready,
    output wsp_pkg::result_t result
);
    import wsp_pkg::*;

    localparam int DEPTH = 3;

    result_t    q_reg [DEPTH];
    result_t    q_next [DEPTH];
    logic [1:0] count_reg, count_next;
    logic [1:0] base;
    logic       pop;

    assign result_valid = (count_reg != 2'd0);
    assign result       = q_reg[0];
    // room only looks at the registered fill, so ready never follows result_ready
    assign room         = (count_reg <= 2'd1);
    assign pop          = result_valid & result_ready;

    always_comb
    begin
        base = count_reg - {1'b0, pop};
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            q_next[i] = pop ? q_reg[i + 1] : q_reg[i];
        end
        q_next[DEPTH-1] = q_reg[DEPTH-1];
        if (push.num != 2'd0)
        begin
            q_next[base] = push.first;
        end
        if (push.num == 2'd2)
        begin
            q_next[base + 2'd1] = push.second;
        end
        count_next = base + push.num;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/wcnf_stream_parser_unit.sv =====
// top level of the weighted-cnf byte stream parser
//
// channel  dir  handshake                    payload
// item     in   item_valid / item_ready      wsp_pkg::item_t (one text byte or end mark)
// result   out  result_valid / result_ready  wsp_pkg::result_t (one event record)
//
// one byte per cycle while the queue has room; a byte that yields two records queues both at once
// a taken byte is held in the input register until the queue has room, then its records are queued
// the three-entry result queue lets input run while a record waits to be taken
// item_ready drops only when the input register is full and at least two records are queued
// rst_n clears the parser to header search and empties the queue
module wcnf_stream_parser_unit #(
    parameter int VAR_BITS = 24,
    parameter int NUM_BITS = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  wsp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output wsp_pkg::result_t result
);
    import wsp_pkg::*;

    push_t push;
    logic  room;

    wsp_core #(
        .VAR_BITS (VAR_BITS),
        .NUM_BITS (NUM_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .room       (room),
        .push       (push)
    );

    wsp_out_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== rtl/core/wsp_port_checker.sv =====
// port-level checks for the wcnf stream parser, bound to the top level
`include "wcnf_stream_parser_unit_assert.svh"

module wsp_port_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input wsp_pkg::result_t result
);
    import wsp_pkg::*;

    logic stalled;
    logic done_seen;
    logic plain_seen;
    logic code_set;

    assign stalled    = result_valid && !result_ready;
    assign done_seen  = result_valid && result.event_res == EV_DONE;
    assign plain_seen = result_valid && result.event_res != EV_ERROR &&
                        result.event_res != EV_DONE;
    assign code_set   = (result.error_code != ERR_NONE);

    // a stalled record stays put
    `WSP_ASSERT_NXT(a_result_hold, stalled, result_valid && $stable(result), "stalled result moved")

    // the done record always closes its byte's run
    `WSP_ASSERT_IMP(a_done_last, done_seen, result.last_of_run, "done record not last of run")

    // input only stalls when records are backed up
    `WSP_ASSERT_IMP(a_stall_backed, !item_ready, result_valid, "input stalled, queue empty")

    // error code only rides on error and done records
    `WSP_ASSERT_IMP(a_code_only, plain_seen, !code_set, "error code on a plain event")

endmodule

bind wcnf_stream_parser_unit wsp_port_checker u_port_checker (.*);

// ===== sim/tb_wcnf_stream_parser_unit.sv =====
// testbench for the wcnf stream parser: generated text streams checked against a local parser
`timescale 1ns / 1ps

module tb_wcnf_stream_parser_unit;
    import wsp_pkg::*;

    typedef enum logic [2:0] {
        PS_SEARCH,
        PS_MATCH,
        PS_HEAD,
        PS_IDLE,
        PS_WEIGHT,
        PS_LITS,
        PS_DISCARD
    } parse_phase_t;

    localparam int unsigned VAR_MAX = (1 << FIELD_W) - 1;
    localparam int unsigned NUM_MAX = 32'((64'd1 << HW_W) - 64'd1);

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    item_t   pending_chars[$];
    result_t step_events[$];
    result_t expected_events[$];
    result_t want_event;
    int      queued_chars;
    int      failures;
    int      send_idle_pct;
    int      recv_stall_pct;

    // parser state mirrored from the text seen so far
    parse_phase_t pr_phase;
    int unsigned  pr_match;
    int unsigned  pr_acc;
    bit           pr_minus;
    bit           pr_plus;
    bit           pr_digits;
    int unsigned  pr_field;
    int unsigned  pr_var_count;
    int unsigned  pr_clause_count;
    int unsigned  pr_top;
    int unsigned  pr_soft;
    int unsigned  pr_next_sel;
    bit           pr_skip;
    string        head_line = "p wcnf";

    wcnf_stream_parser_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit blank_char(logic [7:0] c);
        return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    endfunction

    function automatic bit digit_char(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void reset_parser();
        pr_phase        = PS_SEARCH;
        pr_match        = 0;
        pr_acc          = 0;
        pr_minus        = 1'b0;
        pr_plus         = 1'b0;
        pr_digits       = 1'b0;
        pr_field        = 0;
        pr_var_count    = 0;
        pr_clause_count = 0;
        pr_top          = 0;
        pr_soft         = 0;
        pr_next_sel     = 0;
        pr_skip         = 1'b0;
    endfunction

    // one byte yields at most two records, later ones are dropped
    function automatic void note_event(logic [2:0] ev, int unsigned var_idx, bit neg,
                                       bit soft_flag, int unsigned cnt, int unsigned hw,
                                       logic [2:0] err);
        result_t r;
        if (step_events.size() >= 2)
            return;
        r.event_res   = ev;
        r.var_index   = var_idx[FIELD_W-1:0];
        r.negated     = neg;
        r.soft_clause = soft_flag;
        r.count_value = cnt[FIELD_W-1:0];
        r.hard_weight = hw[HW_W-1:0];
        r.error_code  = err;
        r.last_of_run = 1'b0;
        step_events.push_back(r);
    endfunction

    function automatic void raise_error(logic [2:0] err);
        note_event(EV_ERROR, 0, 1'b0, 1'b0, 0, 0, err);
    endfunction

    function automatic void add_digit(logic [7:0] c);
        int unsigned d;
        d = 32'(c) - 32'(CH_ZERO);
        if (pr_acc > (NUM_MAX - d) / 10)
        begin
            pr_acc = NUM_MAX;
            raise_error(ERR_OVERFLOW);
        end
        else
            pr_acc = pr_acc * 10 + d;
        pr_digits = 1'b1;
    endfunction

    function automatic int unsigned clamp_count(int unsigned v);
        if (v > VAR_MAX)
        begin
            raise_error(ERR_OVERFLOW);
            return VAR_MAX;
        end
        return v;
    endfunction

    function automatic void end_number();
        int unsigned mag;
        bit          neg;
        mag       = pr_acc;
        neg       = pr_minus && mag != 0;
        pr_acc    = 0;
        pr_minus  = 1'b0;
        pr_plus   = 1'b0;
        pr_digits = 1'b0;
        case (pr_phase)
            PS_HEAD:
            begin
                if (pr_field == 0)
                begin
                    pr_var_count = clamp_count(mag);
                    pr_field     = 1;
                end
                else if (pr_field == 1)
                begin
                    pr_clause_count = clamp_count(mag);
                    pr_field        = 2;
                end
                else
                begin
                    pr_top      = mag;
                    pr_next_sel = pr_var_count;
                    note_event(EV_HEADER, pr_var_count, 1'b0, 1'b0, pr_clause_count, pr_top,
                               ERR_NONE);
                    pr_field = 0;
                    pr_phase = PS_IDLE;
                end
            end
            PS_WEIGHT:
            begin
                if (!neg && mag == 1)
                begin
                    note_event(EV_START, pr_next_sel, 1'b0, 1'b1, 0, 0, ERR_NONE);
                    if (pr_next_sel < VAR_MAX)
                        pr_next_sel++;
                    if (pr_soft < VAR_MAX)
                        pr_soft++;
                    pr_phase = PS_LITS;
                end
                else if (!neg && mag == pr_top)
                begin
                    note_event(EV_START, 0, 1'b0, 1'b0, 0, 0, ERR_NONE);
                    pr_phase = PS_LITS;
                end
                else
                begin
                    raise_error(ERR_WEIGHT);
                    pr_phase = PS_DISCARD;
                end
            end
            PS_LITS:
            begin
                if (mag == 0)
                begin
                    note_event(EV_END, 0, 1'b0, 1'b0, 0, 0, ERR_NONE);
                    pr_phase = PS_IDLE;
                end
                else if (mag - 1 > VAR_MAX)
                    raise_error(ERR_OVERFLOW);
                else
                    note_event(EV_LIT, mag - 1, neg, 1'b0, 0, 0, ERR_NONE);
            end
            PS_DISCARD:
            begin
                if (mag == 0)
                    pr_phase = PS_IDLE;
            end
            default:
            begin
            end
        endcase
    endfunction

    // records that one accepted transaction should produce, appended to expected_events
    function automatic void predict_events(item_t it);
        logic [7:0] c;
        logic [2:0] code;
        bit         again;
        result_t    r;
        step_events.delete();
        c = it.data_byte;
        if (it.end_of_input)
        begin
            if (pr_digits)
                end_number();
            if (pr_phase == PS_SEARCH)
                code = ERR_NO_HEADER;
            else if (pr_phase == PS_IDLE)
                code = ERR_NONE;
            else
                code = ERR_CHAR;
            note_event(EV_DONE, 0, 1'b0, 1'b0, pr_soft, 0, code);
            reset_parser();
        end
        else
        begin
            // a byte that ends a number, starts a weight or finds no header is handled again
            again = 1'b1;
            while (again)
            begin
                again = 1'b0;
                if (pr_skip)
                begin
                    if (c == CH_LF)
                    begin
                        pr_skip = 1'b0;
                        continue;
                    end
                    if (c != CH_NUL)
                        continue;
                    pr_skip = 1'b0;
                end
                case (pr_phase)
                    PS_SEARCH:
                    begin
                        if (!blank_char(c))
                        begin
                            if (c == CH_C)
                                pr_skip = 1'b1;
                            else if (c == CH_P)
                            begin
                                pr_phase = PS_MATCH;
                                pr_match = 1;
                            end
                            else
                            begin
                                raise_error(ERR_NO_HEADER);
                                pr_phase = PS_IDLE;
                                again    = 1'b1;
                            end
                        end
                    end
                    PS_MATCH:
                    begin
                        if (pr_match < HEAD_LEN && c == head_line[pr_match])
                        begin
                            pr_match++;
                            if (pr_match == HEAD_LEN)
                            begin
                                pr_match = 0;
                                pr_field = 0;
                                pr_phase = PS_HEAD;
                            end
                        end
                        else
                        begin
                            raise_error(ERR_CHAR);
                            pr_match = 0;
                            pr_phase = PS_IDLE;
                            pr_skip  = (c != CH_LF);
                        end
                    end
                    PS_IDLE:
                    begin
                        if (!blank_char(c))
                        begin
                            if (c == CH_C || c == CH_P)
                                pr_skip = 1'b1;
                            else if (digit_char(c) || c == CH_PLUS || c == CH_MINUS)
                            begin
                                pr_phase = PS_WEIGHT;
                                again    = 1'b1;
                            end
                            else
                                raise_error(ERR_CHAR);
                        end
                    end
                    default:
                    begin
                        if (pr_digits)
                        begin
                            if (digit_char(c))
                                add_digit(c);
                            else
                            begin
                                end_number();
                                again = 1'b1;
                            end
                        end
                        else if (pr_minus || pr_plus)
                        begin
                            if (digit_char(c))
                                add_digit(c);
                            else
                                raise_error(ERR_CHAR);
                        end
                        else if (!blank_char(c))
                        begin
                            if (digit_char(c))
                                add_digit(c);
                            else if (c == CH_PLUS)
                                pr_plus = 1'b1;
                            else if (c == CH_MINUS && pr_phase != PS_HEAD)
                                pr_minus = 1'b1;
                            else
                                raise_error(ERR_CHAR);
                        end
                    end
                endcase
            end
        end
        for (int i = 0; i < step_events.size(); i++)
        begin
            r             = step_events[i];
            r.last_of_run = (i == step_events.size() - 1);
            expected_events.push_back(r);
        end
    endfunction

    task automatic put_char(logic [7:0] b);
        item_t it;
        it.data_byte    = b;
        it.end_of_input = 1'b0;
        pending_chars.push_back(it);
        queued_chars++;
    endtask

    task automatic put_end_mark();
        item_t it;
        it.data_byte    = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        pending_chars.push_back(it);
        queued_chars++;
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endtask

    task automatic put_decimal(longint unsigned v);
        put_text($sformatf("%0d", v));
    endtask

    task automatic put_blank();
        int sel;
        repeat ($urandom_range(1, 2))
        begin
            sel = $urandom_range(0, 7);
            if (sel < 4)
                put_char(CH_SPACE);
            else if (sel == 4)
                put_char(CH_TAB);
            else if (sel == 5)
                put_char(8'(11 + $urandom_range(0, 2)));
            else
                put_char(CH_LF);
        end
    endtask

    task automatic put_comment_line(logic [7:0] lead);
        logic [7:0] ch;
        put_char(lead);
        repeat ($urandom_range(0, 8))
        begin
            ch = 8'($urandom_range(1, 255));
            put_char(ch == CH_LF ? CH_SPACE : ch);
        end
        put_char($urandom_range(0, 5) == 0 ? CH_NUL : CH_LF);
    endtask

    // boundary values around the count and number limits, mixed with random ones
    function automatic longint unsigned pick_magnitude();
        longint unsigned v;
        case ($urandom_range(0, 7))
            0:       v = 64'(VAR_MAX);
            1:       v = 64'(VAR_MAX) + 64'd1;
            2:       v = 64'(VAR_MAX) + 64'd2;
            3:       v = 64'(NUM_MAX);
            4:       v = 64'(NUM_MAX) + 64'd1;
            5:       v = {$urandom, $urandom} % 64'd100_000_000_000;
            default: v = 64'($urandom & NUM_MAX);
        endcase
        return v;
    endfunction

    task automatic put_count_field();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            put_char(CH_PLUS);
        else if (sel == 1)
            put_char(CH_MINUS);
        if (sel < 15)
            put_decimal($urandom_range(0, 24));
        else
            put_decimal(pick_magnitude());
    endtask

    // driver: takes the next byte from pending_chars, predicts on each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            reset_parser();
        end
        else
        begin
            if (item_valid && item_ready)
                predict_events(item);
            if (!item_valid || item_ready)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item       <= pending_chars.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each accepted record with the oldest expected one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: unexpected record ev=%0d err=%0d", $time,
                                 result.event_res, result.error_code);
                end
                else
                begin
                    want_event = expected_events.pop_front();
                    if (result.event_res !== want_event.event_res ||
                        result.var_index !== want_event.var_index ||
                        result.negated !== want_event.negated ||
                        result.soft_clause !== want_event.soft_clause ||
                        result.count_value !== want_event.count_value ||
                        result.hard_weight !== want_event.hard_weight ||
                        result.error_code !== want_event.error_code ||
                        result.last_of_run !== want_event.last_of_run)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display("%0t: record mismatch", $time);
                            $display("  expected ev=%0d var=%0d neg=%0b soft=%0b cnt=%0d",
                                     want_event.event_res, want_event.var_index,
                                     want_event.negated, want_event.soft_clause,
                                     want_event.count_value);
                            $display("           hw=%0d err=%0d last=%0b",
                                     want_event.hard_weight, want_event.error_code,
                                     want_event.last_of_run);
                            $display("  actual   ev=%0d var=%0d neg=%0b soft=%0b cnt=%0d",
                                     result.event_res, result.var_index, result.negated,
                                     result.soft_clause, result.count_value);
                            $display("           hw=%0d err=%0d last=%0b",
                                     result.hard_weight, result.error_code,
                                     result.last_of_run);
                        end
                    end
                end
            end
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        longint unsigned top;
        int              n_clauses;
        int              n_lits;
        int              sel;
        int              k;
        int              phase_no;
        bit              cut;
        failures       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // soft, hard, signed literals, then bytes with no header at all
        put_text("p wcnf 2 1 5\n1 -1 0 5 +2 0");
        put_end_mark();
        put_char(8'hFF);
        put_char(CH_NUL);
        put_end_mark();

        for (phase_no = 0; phase_no < 4; phase_no++)
        begin
            case (phase_no)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default:
                begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
            endcase
            queued_chars = 0;
            while (queued_chars < 110)
            begin
                top = 0;
                repeat ($urandom_range(0, 2))
                begin
                    if ($urandom_range(0, 1) == 0)
                        put_comment_line(CH_C);
                    else
                        put_blank();
                end
                sel = $urandom_range(0, 9);
                if (sel == 7)
                begin
                    put_text("p wc");
                    put_char(8'($urandom_range(0, 255)));
                    put_text("x 1\n");
                end
                else if (sel == 8)
                    put_char(8'($urandom_range(0, 255)));
                else if (sel != 9)
                begin
                    put_text("p wcnf");
                    put_blank();
                    put_count_field();
                    put_blank();
                    put_count_field();
                    put_blank();
                    sel = $urandom_range(0, 19);
                    if (sel == 0)
                        top = 1;
                    else if (sel < 3)
                        top = pick_magnitude();
                    else
                        top = $urandom_range(2, 40);
                    put_decimal(top);
                    put_char(CH_LF);
                end

                n_clauses = $urandom_range(0, 6);
                cut       = ($urandom_range(0, 9) == 0);
                for (k = 0; k < n_clauses; k++)
                begin
                    sel = $urandom_range(0, 19);
                    if (sel == 0)
                        put_comment_line(CH_C);
                    else if (sel == 1)
                        put_comment_line(CH_P);
                    // mostly soft or hard weights, now and then a bad one
                    sel = $urandom_range(0, 19);
                    if (sel < 8)
                        put_decimal(1);
                    else if (sel < 14)
                        put_decimal(top);
                    else if (sel == 14)
                    begin
                        put_char(CH_MINUS);
                        put_decimal($urandom_range(0, 1) ? top : 1);
                    end
                    else if (sel == 15)
                    begin
                        if ($urandom_range(0, 1))
                            put_char(CH_MINUS);
                        put_char(CH_ZERO);
                    end
                    else if (sel == 16)
                        put_decimal(pick_magnitude());
                    else if (sel == 17)
                        put_text("+1");
                    else if (sel == 18)
                    begin
                        put_char(8'($urandom_range(0, 255)));
                        put_blank();
                        put_decimal(1);
                    end
                    else
                        put_decimal($urandom_range(2, 9));

                    n_lits = $urandom_range(0, 4);
                    repeat (n_lits)
                    begin
                        put_blank();
                        sel = $urandom_range(0, 19);
                        if (sel < 6)
                            put_char(CH_MINUS);
                        else if (sel == 6)
                            put_char(CH_PLUS);
                        else if (sel == 7)
                        begin
                            // sign followed by a blank instead of a digit
                            put_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                            put_blank();
                        end
                        else if (sel == 8)
                            put_char(8'($urandom_range(0, 255)));
                        if (sel == 9)
                            put_decimal(pick_magnitude());
                        else
                            put_decimal($urandom_range(1, 30));
                    end
                    if (cut && k == n_clauses - 1)
                        break;
                    put_blank();
                    put_char(CH_ZERO);
                    put_char(CH_LF);
                end
                put_end_mark();
            end

            // hold the sender until every expected transaction has come back
            while (pending_chars.size() != 0 || item_valid || expected_events.size() != 0)
                @(posedge clk);
            repeat (10) @(posedge clk);
            @(negedge clk);
        end

        repeat (20) @(posedge clk);
        if (failures == 0 && expected_events.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
